### rtl/srfs_pkg.sv
// Shared types and constants for the series relay feedback supervisor.
`timescale 1ns / 1ps

package srfs_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned SETTLE_W = 16;
    localparam int unsigned LIMIT_W  = 8;
    localparam int unsigned RUN_W    = 16;
    localparam int unsigned TOTAL_W  = 32;
    localparam int unsigned NUM_CH   = 2;
    localparam int unsigned CFG_W    = 16;

    localparam logic [SETTLE_W-1:0] SETTLE_RESET = SETTLE_W'(100);
    localparam logic [LIMIT_W-1:0]  STOP_RESET   = LIMIT_W'(10);

    typedef enum logic [0:0] {
        CFG_SETTLE_MS  = 1'b0,
        CFG_STOP_TICKS = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [NUM_CH-1:0]             level;
        logic [NUM_CH-1:0][TIME_W-1:0] ctime;
        logic [NUM_CH-1:0][RUN_W-1:0]  run;
        logic [TOTAL_W-1:0]            total;
        logic                          stop;
    } t_state;

endpackage

### rtl/series_relay_feedback_supervisor.sv
// An accepted tick reaches its result beat via the input register, then the result register.
// One tick per cycle unless the output stalls; the whole update sits between the two registers.
// The supervisor state is the result register, so each tick sees the previous tick's update.
// Reset (synchronous, active low) opens both relays, clears times and counters,
// and loads settle_ms = 100 and stop_ticks = 10.
`timescale 1ns / 1ps

module series_relay_feedback_supervisor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Tick input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_chan_a_run,
    input  logic                            i_chan_b_run,
    input  logic                            i_sense_a,
    input  logic                            i_sense_b,
    input  logic [srfs_pkg::TIME_W-1:0]     i_time_ms,
    // Result channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_drive_a,
    output logic                            o_drive_b,
    output logic [srfs_pkg::RUN_W-1:0]      o_fault_ticks_a,
    output logic [srfs_pkg::RUN_W-1:0]      o_fault_ticks_b,
    output logic [srfs_pkg::TOTAL_W-1:0]    o_fault_sum,
    output logic                            o_force_stop,
    // Configuration write port
    input  logic                            i_cfg_we,
    input  logic [0:0]                      i_cfg_idx,
    input  logic [srfs_pkg::CFG_W-1:0]      i_cfg_data
);
    import srfs_pkg::*;

    logic [SETTLE_W-1:0] r_settle_ms;
    logic [LIMIT_W-1:0]  r_stop_ticks;

    logic                r_in_valid;
    logic [NUM_CH-1:0]   r_run;
    logic [NUM_CH-1:0]   r_sense;
    logic [TIME_W-1:0]   r_now;

    logic                r_out_valid;
    t_state              r_state;
    t_state              n_state;

    logic                out_ready;
    logic                advance;
    logic                in_take;

    assign out_ready  = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_ready;
    assign o_in_stall = r_in_valid && !out_ready;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_ms  <= SETTLE_RESET;
            r_stop_ticks <= STOP_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_SETTLE_MS:  r_settle_ms  <= i_cfg_data[SETTLE_W-1:0];
                CFG_STOP_TICKS: r_stop_ticks <= i_cfg_data[LIMIT_W-1:0];
                default:        r_settle_ms  <= r_settle_ms;
            endcase
        end
    end

    // Input register stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_run   <= {i_chan_b_run, i_chan_a_run};
            r_sense <= {i_sense_b, i_sense_a};
            r_now   <= i_time_ms;
        end
    end

    srfs_update u_update (
        .i_state      (r_state),
        .i_run        (r_run),
        .i_sense      (r_sense),
        .i_now        (r_now),
        .i_settle_ms  (r_settle_ms),
        .i_stop_ticks (r_stop_ticks),
        .o_state      (n_state)
    );

    // The state register doubles as the result register: it only moves when
    // the previous beat has been taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_drive_a       = r_state.level[0];
    assign o_drive_b       = r_state.level[1];
    assign o_fault_ticks_a = r_state.run[0];
    assign o_fault_ticks_b = r_state.run[1];
    assign o_fault_sum     = r_state.total;
    assign o_force_stop    = r_state.stop;

`ifndef ASSERT_OFF
    a_stop_matches_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state.stop == ((r_state.run[0] >= RUN_W'(r_stop_ticks)) ||
                                          (r_state.run[1] >= RUN_W'(r_stop_ticks)))))
        else $error("force_stop disagrees with channel counts");

    a_total_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_state.total >= $past(r_state.total)))
        else $error("fault total decreased");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled while the pipeline can move");
`endif

endmodule

### rtl/srfs_update.sv
// Per-tick state update: command latch, series-chain check, counters, stop.
`timescale 1ns / 1ps

module srfs_update (
    input  srfs_pkg::t_state                   i_state,
    input  logic [srfs_pkg::NUM_CH-1:0]        i_run,
    input  logic [srfs_pkg::NUM_CH-1:0]        i_sense,
    input  logic [srfs_pkg::TIME_W-1:0]        i_now,
    input  logic [srfs_pkg::SETTLE_W-1:0]      i_settle_ms,
    input  logic [srfs_pkg::LIMIT_W-1:0]       i_stop_ticks,
    output srfs_pkg::t_state                   o_state
);
    import srfs_pkg::*;

    logic [NUM_CH-1:0]             expect_lvl;
    logic [NUM_CH-1:0][TIME_W-1:0] age;
    logic [NUM_CH-1:0]             counted;
    logic                          settled;
    logic [TOTAL_W:0]              total_sum;

    always_comb begin
        o_state = i_state;

        // Commands are latched first; a change restarts that channel's clock.
        for (int ch = 0; ch < NUM_CH; ch++) begin
            if (i_run[ch] != i_state.level[ch]) begin
                o_state.level[ch] = i_run[ch];
                o_state.ctime[ch] = i_now;
            end
            age[ch] = i_now - o_state.ctime[ch];
        end

        expect_lvl[0] = o_state.level[0];
        expect_lvl[1] = o_state.level[0] & o_state.level[1];
        settled = (age[0] >= TIME_W'(i_settle_ms)) && (age[1] >= TIME_W'(i_settle_ms));

        for (int ch = 0; ch < NUM_CH; ch++) begin
            counted[ch] = 1'b0;
            if (i_sense[ch] == expect_lvl[ch]) begin
                o_state.run[ch] = '0;
            end else if (settled) begin
                counted[ch] = 1'b1;
                if (i_state.run[ch] != {RUN_W{1'b1}}) begin
                    o_state.run[ch] = i_state.run[ch] + RUN_W'(1);
                end
            end
        end

        total_sum = {1'b0, i_state.total} + (TOTAL_W+1)'(counted[0])
                    + (TOTAL_W+1)'(counted[1]);
        o_state.total = total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];

        o_state.stop = (o_state.run[0] >= RUN_W'(i_stop_ticks)) ||
                       (o_state.run[1] >= RUN_W'(i_stop_ticks));
    end

endmodule
